// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- rtl/hmt_pkg.sv -----
package hmt_pkg;

   localparam int unsigned TableDepthDefault = 32;
   localparam int unsigned QueueDepth        = 2;

   localparam int unsigned ID_W    = 32;
   localparam int unsigned PORT_W  = 16;
   localparam int unsigned BEAT_W  = 32;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned TMO_W   = 16;
   localparam int unsigned AVAIL_W = 6;

   localparam logic [ID_W-1:0]   SELF_ID_RESET        = 32'd1;
   localparam logic [PORT_W-1:0] SELF_PORT_RESET      = 16'd0;
   localparam logic [TMO_W-1:0]  FAIL_TIMEOUT_RESET   = 16'd5;
   localparam logic [TMO_W-1:0]  REMOVE_TIMEOUT_RESET = 16'd20;

   typedef enum logic [1:0] {
      OP_MERGE   = 2'd0,
      OP_TICK    = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_SELF_ID        = 2'd0,
      CSR_SELF_PORT      = 2'd1,
      CSR_FAIL_TIMEOUT   = 2'd2,
      CSR_REMOVE_TIMEOUT = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      STATUS_ADDED     = 3'd0,
      STATUS_UPDATED   = 3'd1,
      STATUS_IGNORED   = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_REMOVED   = 3'd4,
      STATUS_TICK      = 3'd5,
      STATUS_RESTARTED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MSCAN,
      ST_MDONE,
      ST_TSCAN,
      ST_TDONE,
      ST_RDONE
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [ID_W-1:0]     node_id;
      logic [PORT_W-1:0]   node_port;
      logic [BEAT_W-1:0]   member_heartbeat;
      logic [TIME_W-1:0]   current_time;
   } item_type;

   typedef struct packed {
      logic [ID_W-1:0]     self_id;
      logic [PORT_W-1:0]   self_port;
      logic [TMO_W-1:0]    fail_timeout;
      logic [TMO_W-1:0]    remove_timeout;
   } cfg_type;

   typedef struct packed {
      logic [ID_W-1:0]     node_id;
      logic [PORT_W-1:0]   node_port;
      logic [BEAT_W-1:0]   heartbeat;
      logic [TIME_W-1:0]   timestamp;
   } slot_type;

endpackage

// ----- rtl/heartbeat_membership_table_core.sv -----
// channel   direction  handshake              payload
// req_      in         req_valid/req_ready    operation, member id/port/heartbeat, time
// rsp_      out        rsp_valid/rsp_ready    status, entry id/port, available count, last
// csr_      in         csr_valid/csr_ready    register index, write data
//
// a merge scans the slots, one slot read per cycle, and stops at a match; it skips the scan when it names self
// a tick scans the slots and is stalled while the result side cannot take a removal
// a restart needs no clearing pass, and none is needed after reset
// a two-entry queue lets new transactions arrive while the table engine is busy
// synchronous active-high reset clears the valid bits of all slots but slot zero, and the self heartbeat
// the one-entry result register holds a result while rsp_ready is low
module heartbeat_membership_table_core #(
   parameter int unsigned TABLE_DEPTH = hmt_pkg::TableDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   // request transaction
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_operation,
   input  logic [hmt_pkg::ID_W-1:0]       req_member_id,
   input  logic [hmt_pkg::PORT_W-1:0]     req_member_port,
   input  logic [hmt_pkg::BEAT_W-1:0]     req_member_heartbeat,
   input  logic [hmt_pkg::TIME_W-1:0]     req_current_time,
   // response transaction
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic [hmt_pkg::ID_W-1:0]       rsp_entry_id,
   output logic [hmt_pkg::PORT_W-1:0]     rsp_entry_port,
   output logic [hmt_pkg::AVAIL_W-1:0]    rsp_available_count,
   output logic                           rsp_last,
   // register write transaction
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [31:0]                    csr_data
);

   // configuration registers
   logic [hmt_pkg::ID_W-1:0]   self_id_ff, self_id_in;
   logic [hmt_pkg::PORT_W-1:0] self_port_ff, self_port_in;
   logic [hmt_pkg::TMO_W-1:0]  fail_tmo_ff, fail_tmo_in;
   logic [hmt_pkg::TMO_W-1:0]  remove_tmo_ff, remove_tmo_in;

   hmt_pkg::cfg_type  cfg;
   logic              q_valid;
   logic              q_pop;
   hmt_pkg::item_type q_item;

   // the user must write only while idle; the block does not enforce it, and writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      self_id_in    = self_id_ff;
      self_port_in  = self_port_ff;
      fail_tmo_in   = fail_tmo_ff;
      remove_tmo_in = remove_tmo_ff;
      if (csr_valid) begin
         case (csr_index)
            hmt_pkg::CSR_SELF_ID:        self_id_in    = csr_data;
            hmt_pkg::CSR_SELF_PORT:      self_port_in  = csr_data[hmt_pkg::PORT_W-1:0];
            hmt_pkg::CSR_FAIL_TIMEOUT:   fail_tmo_in   = csr_data[hmt_pkg::TMO_W-1:0];
            hmt_pkg::CSR_REMOVE_TIMEOUT: remove_tmo_in = csr_data[hmt_pkg::TMO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         self_id_ff    <= hmt_pkg::SELF_ID_RESET;
         self_port_ff  <= hmt_pkg::SELF_PORT_RESET;
         fail_tmo_ff   <= hmt_pkg::FAIL_TIMEOUT_RESET;
         remove_tmo_ff <= hmt_pkg::REMOVE_TIMEOUT_RESET;
      end else begin
         self_id_ff    <= self_id_in;
         self_port_ff  <= self_port_in;
         fail_tmo_ff   <= fail_tmo_in;
         remove_tmo_ff <= remove_tmo_in;
      end
   end

   // slot zero id and port are read straight from the self registers
   assign cfg = '{self_id:        self_id_ff,
                  self_port:      self_port_ff,
                  fail_timeout:   fail_tmo_ff,
                  remove_timeout: remove_tmo_ff};

   // front: accept, drop unused codes, queue
   hmt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_member_id       (req_member_id),
      .req_member_port     (req_member_port),
      .req_member_heartbeat(req_member_heartbeat),
      .req_current_time    (req_current_time),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop)
   );

   // back: table engine with slot ram and result register
   hmt_back #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_entry_id       (rsp_entry_id),
      .rsp_entry_port     (rsp_entry_port),
      .rsp_available_count(rsp_available_count),
      .rsp_last           (rsp_last)
   );

endmodule

// ----- rtl/hmt_ram.sv -----
module hmt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rdata = rd_data_ff;

endmodule

// ----- rtl/hmt_front.sv -----
`include "assert_macros.svh"

module hmt_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic [hmt_pkg::ID_W-1:0]          req_member_id,
   input  logic [hmt_pkg::PORT_W-1:0]        req_member_port,
   input  logic [hmt_pkg::BEAT_W-1:0]        req_member_heartbeat,
   input  logic [hmt_pkg::TIME_W-1:0]        req_current_time,
   output logic                              q_valid,
   output hmt_pkg::item_type                 q_item,
   input  logic                              q_pop
);

   localparam int unsigned PTR_W = (hmt_pkg::QueueDepth > 1) ? $clog2(hmt_pkg::QueueDepth) : 1;
   localparam int unsigned CNT_W = $clog2(hmt_pkg::QueueDepth + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(hmt_pkg::QueueDepth - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(hmt_pkg::QueueDepth);

   hmt_pkg::item_type q_mem_ff [hmt_pkg::QueueDepth];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   hmt_pkg::item_type new_item;
   logic              keep;
   logic              push;

   // classify: unused operation code is dropped here
   always_comb begin
      new_item.node_id          = req_member_id;
      new_item.node_port        = req_member_port;
      new_item.member_heartbeat = req_member_heartbeat;
      new_item.current_time     = req_current_time;
      new_item.op               = hmt_pkg::OP_MERGE;
      keep                      = 1'b1;
      case (req_operation)
         hmt_pkg::OP_MERGE: begin
            new_item.op = hmt_pkg::OP_MERGE;
         end
         hmt_pkg::OP_TICK: begin
            new_item.op = hmt_pkg::OP_TICK;
         end
         hmt_pkg::OP_RESTART: begin
            new_item.op = hmt_pkg::OP_RESTART;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = (count_ff != CNT_FULL);
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   `ASSERT_NEVER(a_queue_overfill, clock, reset, count_ff > CNT_FULL)
   `ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && (count_ff == '0))
   `ASSERT_PROP(a_head_stable, clock, reset, (q_valid && !q_pop) |=> $stable(q_item))

endmodule

// ----- rtl/hmt_back.sv -----
`include "assert_macros.svh"

module hmt_back #(
   parameter int unsigned TABLE_DEPTH = hmt_pkg::TableDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hmt_pkg::cfg_type               cfg,
   input  logic                           q_valid,
   input  hmt_pkg::item_type              q_item,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic [hmt_pkg::ID_W-1:0]       rsp_entry_id,
   output logic [hmt_pkg::PORT_W-1:0]     rsp_entry_port,
   output logic [hmt_pkg::AVAIL_W-1:0]    rsp_available_count,
   output logic                           rsp_last
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam int unsigned SUM_W = hmt_pkg::TIME_W + 1;

   hmt_pkg::state_type state_ff, state_in;
   hmt_pkg::item_type  cur_ff, cur_in;
   logic [TABLE_DEPTH-1:0]         valid_ff, valid_in;
   logic [hmt_pkg::BEAT_W-1:0]     self_hb_ff, self_hb_in;
   logic [CNT_W-1:0]               rd_idx_ff, rd_idx_in;
   logic                           eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]               eval_idx_ff, eval_idx_in;
   logic                           hit_ff, hit_in;
   logic [IDX_W-1:0]               hit_idx_ff, hit_idx_in;
   logic [hmt_pkg::BEAT_W-1:0]     hit_hb_ff, hit_hb_in;
   logic                           free_found_ff, free_found_in;
   logic [IDX_W-1:0]               free_idx_ff, free_idx_in;
   logic [hmt_pkg::AVAIL_W-1:0]    avail_ff, avail_in;

   logic                           rsp_valid_ff;
   hmt_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [hmt_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [hmt_pkg::PORT_W-1:0]     rsp_port_ff, rsp_port_in;
   logic [hmt_pkg::AVAIL_W-1:0]    rsp_avail_ff, rsp_avail_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_load;

   logic                           ram_we;
   logic [IDX_W-1:0]               ram_addr;
   hmt_pkg::slot_type              ram_wdata;
   hmt_pkg::slot_type              ram_rdata;

   logic                           out_free;
   logic                           issue_more;
   logic                           scan_done;
   logic                           eval_live;
   logic                           id_match;
   logic                           head_self;
   logic [SUM_W-1:0]               rem_sum;
   logic [SUM_W-1:0]               fail_sum;
   logic [SUM_W-1:0]               now_ext;
   logic                           remove_hit;
   logic                           avail_hit;
   logic                           t_stall;

   hmt_ram #(
      .WIDTH($bits(hmt_pkg::slot_type)),
      .DEPTH(TABLE_DEPTH)
   ) u_slot_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign issue_more = (rd_idx_ff != DEPTH_CNT);
   assign scan_done  = !eval_vld_ff && !issue_more;
   assign eval_live  = eval_vld_ff && valid_ff[eval_idx_ff];
   assign id_match   = (ram_rdata.node_id == cur_ff.node_id) &&
                       (ram_rdata.node_port == cur_ff.node_port);
   assign head_self  = (q_item.node_id == cfg.self_id) &&
                       (q_item.node_port == cfg.self_port);
   assign now_ext    = {1'b0, cur_ff.current_time};
   assign rem_sum    = {1'b0, ram_rdata.timestamp} + SUM_W'(cfg.remove_timeout);
   assign fail_sum   = {1'b0, ram_rdata.timestamp} + SUM_W'(cfg.fail_timeout);
   assign remove_hit = rem_sum < now_ext;
   assign avail_hit  = fail_sum >= now_ext;
   assign t_stall    = (state_ff == hmt_pkg::ST_TSCAN) && eval_live && remove_hit && !out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hmt_pkg::ST_IDLE: begin
            if (q_valid) begin
               case (q_item.op)
                  hmt_pkg::OP_MERGE:   state_in = head_self ? hmt_pkg::ST_MDONE : hmt_pkg::ST_MSCAN;
                  hmt_pkg::OP_TICK:    state_in = hmt_pkg::ST_TSCAN;
                  hmt_pkg::OP_RESTART: state_in = hmt_pkg::ST_RDONE;
                  default:             state_in = hmt_pkg::ST_IDLE;
               endcase
            end
         end
         hmt_pkg::ST_MSCAN: begin
            if ((eval_live && id_match) || scan_done) begin
               state_in = hmt_pkg::ST_MDONE;
            end
         end
         hmt_pkg::ST_TSCAN: begin
            if (scan_done) begin
               state_in = hmt_pkg::ST_TDONE;
            end
         end
         hmt_pkg::ST_MDONE, hmt_pkg::ST_TDONE, hmt_pkg::ST_RDONE: begin
            if (out_free) begin
               state_in = hmt_pkg::ST_IDLE;
            end
         end
         default: state_in = hmt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cur_in        = cur_ff;
      valid_in      = valid_ff;
      self_hb_in    = self_hb_ff;
      rd_idx_in     = rd_idx_ff;
      eval_vld_in   = eval_vld_ff;
      eval_idx_in   = eval_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_hb_in     = hit_hb_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      avail_in      = avail_ff;
      q_pop         = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = hmt_pkg::STATUS_TICK;
      rsp_id_in     = cur_ff.node_id;
      rsp_port_in   = cur_ff.node_port;
      rsp_avail_in  = '0;
      rsp_last_in   = 1'b1;
      ram_we        = 1'b0;
      ram_addr      = issue_more ? rd_idx_ff[IDX_W-1:0] : '0;
      ram_wdata     = '{node_id:          cur_ff.node_id,
                        node_port:        cur_ff.node_port,
                        heartbeat:        cur_ff.member_heartbeat,
                        timestamp:        cur_ff.current_time};
      case (state_ff)
         hmt_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               cur_in        = q_item;
               rd_idx_in     = CNT_W'(1);
               eval_vld_in   = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               avail_in      = hmt_pkg::AVAIL_W'(1);
               if (q_item.op == hmt_pkg::OP_MERGE && head_self) begin
                  hit_in     = 1'b1;
                  hit_idx_in = '0;
                  hit_hb_in  = self_hb_ff;
               end
               if (q_item.op == hmt_pkg::OP_TICK) begin
                  self_hb_in = (self_hb_ff == '1) ? self_hb_ff : self_hb_ff + 1'b1;
               end
            end
         end
         hmt_pkg::ST_MSCAN: begin
            rd_idx_in   = issue_more ? rd_idx_ff + CNT_W'(1) : rd_idx_ff;
            eval_vld_in = issue_more;
            eval_idx_in = rd_idx_ff[IDX_W-1:0];
            if (eval_vld_ff && !valid_ff[eval_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = eval_idx_ff;
            end
            if (eval_live && id_match) begin
               hit_in     = 1'b1;
               hit_idx_in = eval_idx_ff;
               hit_hb_in  = ram_rdata.heartbeat;
            end
         end
         hmt_pkg::ST_MDONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (hit_ff) begin
                  if (cur_ff.member_heartbeat > hit_hb_ff) begin
                     rsp_status_in = hmt_pkg::STATUS_UPDATED;
                     if (hit_idx_ff == '0) begin
                        self_hb_in = cur_ff.member_heartbeat;
                     end else begin
                        ram_we   = 1'b1;
                        ram_addr = hit_idx_ff;
                     end
                  end else begin
                     rsp_status_in = hmt_pkg::STATUS_IGNORED;
                  end
               end else if (free_found_ff) begin
                  rsp_status_in         = hmt_pkg::STATUS_ADDED;
                  ram_we                = 1'b1;
                  ram_addr              = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
               end else begin
                  rsp_status_in = hmt_pkg::STATUS_FULL;
               end
            end
         end
         hmt_pkg::ST_TSCAN: begin
            if (t_stall) begin
               // re-read the held slot so its data stays on the ram output
               ram_addr = eval_idx_ff;
            end else begin
               rd_idx_in   = issue_more ? rd_idx_ff + CNT_W'(1) : rd_idx_ff;
               eval_vld_in = issue_more;
               eval_idx_in = rd_idx_ff[IDX_W-1:0];
               if (eval_live) begin
                  if (remove_hit) begin
                     valid_in[eval_idx_ff] = 1'b0;
                     rsp_load              = 1'b1;
                     rsp_status_in         = hmt_pkg::STATUS_REMOVED;
                     rsp_id_in             = ram_rdata.node_id;
                     rsp_port_in           = ram_rdata.node_port;
                     rsp_last_in           = 1'b0;
                  end else if (avail_hit) begin
                     avail_in = avail_ff + hmt_pkg::AVAIL_W'(1);
                  end
               end
            end
         end
         hmt_pkg::ST_TDONE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = hmt_pkg::STATUS_TICK;
               rsp_id_in     = '0;
               rsp_port_in   = '0;
               rsp_avail_in  = avail_ff;
            end
         end
         hmt_pkg::ST_RDONE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = hmt_pkg::STATUS_RESTARTED;
               rsp_id_in     = cfg.self_id;
               rsp_port_in   = cfg.self_port;
               valid_in      = TABLE_DEPTH'(1);
               self_hb_in    = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hmt_pkg::ST_IDLE;
         valid_ff     <= TABLE_DEPTH'(1);
         self_hb_ff   <= '0;
         eval_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         self_hb_ff   <= self_hb_in;
         eval_vld_ff  <= eval_vld_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rd_idx_ff     <= rd_idx_in;
      eval_idx_ff   <= eval_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_hb_ff     <= hit_hb_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      avail_ff      <= avail_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_port_ff   <= rsp_port_in;
         rsp_avail_ff  <= rsp_avail_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_id        = rsp_id_ff;
   assign rsp_entry_port      = rsp_port_ff;
   assign rsp_available_count = rsp_avail_ff;
   assign rsp_last            = rsp_last_ff;

   `ASSERT_PROP(a_self_slot_valid, clock, reset, valid_ff[0])
   `ASSERT_PROP(a_load_when_free, clock, reset, rsp_load |-> out_free)
   `ASSERT_PROP(a_ram_write_merge, clock, reset, ram_we |-> (state_ff == hmt_pkg::ST_MDONE))
   `ASSERT_PROP(a_stall_holds_scan, clock, reset, t_stall |=> ($stable(eval_idx_ff) && $stable(rd_idx_ff)))

endmodule
